FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. All are clocked on clk and are off
// while arst_n is low. They compile away in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every edge
`define UCC_CHECK(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);
// Same-cycle implication
`define UCC_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define UCC_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define UCC_CHECK(label, expr, msg)
`define UCC_IMPLY(label, ante, cons, msg)
`define UCC_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/ucc_pkg.sv
// ---------------------------------------------------------------------------
// UTF-8 case converter package
// Types, codepoint constants and the case mapping and encoding functions.
// ---------------------------------------------------------------------------
`default_nettype none

package ucc_pkg;

	// Case modes
	localparam logic [1:0] MODE_LOWER = 2'd0;
	localparam logic [1:0] MODE_UPPER = 2'd1;
	localparam logic [1:0] MODE_TITLE = 2'd2;

	// Codepoints with special handling
	localparam logic [20:0] CP_SHARP_S     = 21'h0000DF;
	localparam logic [20:0] CP_CAP_SIGMA   = 21'h0003A3;
	localparam logic [20:0] CP_FINAL_SIGMA = 21'h0003C2;
	localparam logic [20:0] CP_SMALL_SIGMA = 21'h0003C3;
	localparam logic [20:0] CP_TIMES       = 21'h0000D7;
	localparam logic [20:0] CP_DIVIDE      = 21'h0000F7;
	localparam logic [20:0] CP_Y_DIAER_CAP = 21'h000178;
	localparam logic [20:0] CP_LONG_S      = 21'h00017F;
	localparam logic [20:0] CP_GREEK_GAP   = 21'h0003A2;
	localparam logic [20:0] CP_Y_DIAER     = 21'h0000FF;
	localparam logic [15:0] BYTES_SS       = 16'h5353;

	// One decoded input: held bytes to flush, then an optional codepoint
	typedef struct packed {
		logic [3:0][7:0] flush;
		logic [2:0]      fcnt;
		logic            has_cp;
		logic [20:0]     cp;
		logic            eos;
	} entry_t;

	// Encoded form: first byte in bits 7:0
	typedef struct packed {
		logic [31:0] bytes;
		logic [2:0]  n;
	} enc_t;

	function automatic logic [2:0] seq_len(input logic [7:0] lead);
		logic [2:0] r;
		r = 3'd1;
		if (lead[7:5] == 3'b110) r = 3'd2;
		else if (lead[7:4] == 4'b1110) r = 3'd3;
		else if (lead[7:3] == 5'b11110) r = 3'd4;
		return r;
	endfunction

	function automatic logic is_word(input logic [20:0] c);
		logic r;
		r = 1'b1;
		if (c < 21'h80) begin
			r = (c inside {[21'h61:21'h7A], [21'h41:21'h5A], [21'h30:21'h39]});
		end
		return r;
	endfunction

	function automatic logic [20:0] map_lower(input logic [20:0] c);
		logic [20:0] r;
		r = c;
		if (c < 21'h80) begin
			if (c inside {[21'h41:21'h5A]}) r = c + 21'h20;
		end else if (c inside {[21'hC0:21'hDE]} && c != CP_TIMES) begin
			r = c + 21'h20;
		end else if (c inside {[21'h100:21'h137], [21'h14A:21'h177]}) begin
			r = c | 21'h1;
		end else if (c inside {[21'h139:21'h148], [21'h179:21'h17E]}) begin
			r = ((c - 21'h1) | 21'h1) + 21'h1;
		end else if (c == CP_Y_DIAER_CAP) begin
			r = CP_Y_DIAER;
		end else if (c inside {[21'h391:21'h3A9]} && c != CP_GREEK_GAP) begin
			r = c + 21'h20;
		end else if (c inside {[21'h410:21'h42F]}) begin
			r = c + 21'h20;
		end else if (c inside {[21'h400:21'h40F]}) begin
			r = c + 21'h50;
		end
		return r;
	endfunction

	function automatic logic [20:0] map_upper(input logic [20:0] c);
		logic [20:0] r;
		r = c;
		if (c < 21'h80) begin
			if (c inside {[21'h61:21'h7A]}) r = c - 21'h20;
		end else if (c inside {[21'hE0:21'hFE]} && c != CP_DIVIDE) begin
			r = c - 21'h20;
		end else if (c == CP_Y_DIAER) begin
			r = CP_Y_DIAER_CAP;
		end else if (c inside {[21'h100:21'h137], [21'h14A:21'h177]}) begin
			r = c & ~21'h1;
		end else if (c inside {[21'h139:21'h148], [21'h179:21'h17E]}) begin
			r = ((c - 21'h1) & ~21'h1) + 21'h1;
		end else if (c == CP_LONG_S) begin
			r = 21'h53;
		end else if (c inside {[21'h3B1:21'h3C9]} && c != CP_FINAL_SIGMA) begin
			r = c - 21'h20;
		end else if (c == CP_FINAL_SIGMA) begin
			r = CP_CAP_SIGMA;
		end else if (c inside {[21'h430:21'h44F]}) begin
			r = c - 21'h20;
		end else if (c inside {[21'h450:21'h45F]}) begin
			r = c - 21'h50;
		end
		return r;
	endfunction

	function automatic enc_t encode(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp < 21'h80) begin
			e.bytes[7:0] = cp[7:0];
			e.n = 3'd1;
		end else if (cp < 21'h800) begin
			e.bytes[7:0]   = {3'b110, cp[10:6]};
			e.bytes[15:8]  = {2'b10, cp[5:0]};
			e.n = 3'd2;
		end else if (cp < 21'h10000) begin
			e.bytes[7:0]   = {4'b1110, cp[15:12]};
			e.bytes[15:8]  = {2'b10, cp[11:6]};
			e.bytes[23:16] = {2'b10, cp[5:0]};
			e.n = 3'd3;
		end else begin
			e.bytes[7:0]   = {5'b11110, cp[20:18]};
			e.bytes[15:8]  = {2'b10, cp[17:12]};
			e.bytes[23:16] = {2'b10, cp[11:6]};
			e.bytes[31:24] = {2'b10, cp[5:0]};
			e.n = 3'd4;
		end
		return e;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ucc_if.sv
// ---------------------------------------------------------------------------
// UTF-8 case converter channels
// Valid/ready byte channels for the input string and the mapped output.
// ---------------------------------------------------------------------------
`default_nettype none

interface ucc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;
	modport source (output valid, in_byte, end_of_string, input ready);
	modport sink (input valid, in_byte, end_of_string, output ready);
endinterface

interface ucc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_done;
	modport source (output valid, out_byte, run_last, string_done, input ready);
	modport sink (input valid, out_byte, run_last, string_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/ucc_front.sv
// ---------------------------------------------------------------------------
// UTF-8 decoder front end
// Takes one byte per cycle while the queue has room, tracks unfinished
// sequences and queues entries of held bytes plus an optional codepoint.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ucc_front (
	input  logic            clk,
	input  logic            arst_n,
	ucc_in_if.sink          raw,
	input  logic            q_full,
	output logic            q_push,
	output ucc_pkg::entry_t q_entry
);

	logic [7:0] held_q [3];
	logic [1:0] held_cnt_q;
	logic [7:0] held_n [3];
	logic [1:0] cnt_n;
	logic       cont;
	logic [2:0] need;
	logic       accept;
	ucc_pkg::entry_t e;

	assign raw.ready = !q_full;
	assign accept    = raw.valid && raw.ready;

	// Decode the incoming byte against the held sequence
	always_comb begin
		cont   = (raw.in_byte[7:6] == 2'b10);
		need   = ucc_pkg::seq_len(held_q[0]);
		held_n = held_q;
		cnt_n  = held_cnt_q;
		e      = '0;
		e.eos  = raw.end_of_string;
		e.flush[0] = held_q[0];
		e.flush[1] = held_q[1];
		e.flush[2] = held_q[2];
		if (held_cnt_q != 2'd0 && cont) begin
			if ({1'b0, held_cnt_q} + 3'd1 == need) begin
				e.has_cp = 1'b1;
				cnt_n    = 2'd0;
				if (need == 3'd2) begin
					e.cp = {10'd0, held_q[0][4:0], raw.in_byte[5:0]};
				end else if (need == 3'd3) begin
					e.cp = {5'd0, held_q[0][3:0], held_q[1][5:0], raw.in_byte[5:0]};
				end else begin
					e.cp = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0],
						raw.in_byte[5:0]};
				end
			end else if (held_cnt_q != 2'd3) begin
				held_n[held_cnt_q] = raw.in_byte;
				cnt_n = held_cnt_q + 2'd1;
			end
			// End of string flushes whatever stays held
			if (raw.end_of_string && !e.has_cp) begin
				e.flush[0] = held_n[0];
				e.flush[1] = held_n[1];
				e.flush[2] = held_n[2];
				e.fcnt     = {1'b0, cnt_n};
				cnt_n      = 2'd0;
			end
		end else begin
			e.fcnt = {1'b0, held_cnt_q};
			if (ucc_pkg::seq_len(raw.in_byte) == 3'd1) begin
				e.has_cp = 1'b1;
				e.cp     = {13'd0, raw.in_byte};
				cnt_n    = 2'd0;
			end else if (raw.end_of_string) begin
				e.flush[held_cnt_q] = raw.in_byte;
				e.fcnt = {1'b0, held_cnt_q} + 3'd1;
				cnt_n  = 2'd0;
			end else begin
				held_n[0] = raw.in_byte;
				cnt_n     = 2'd1;
			end
		end
	end

	assign q_entry = e;
	assign q_push  = accept && (e.fcnt != 3'd0 || e.has_cp || e.eos);

	// Hold the sequence count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
		end else if (accept) begin
			held_cnt_q <= cnt_n;
		end
	end

	// Hold the sequence bytes
	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_n;
		end
	end

	`UCC_IMPLY(a_held_is_lead, held_cnt_q != 2'd0, ucc_pkg::seq_len(held_q[0]) != 3'd1,
		"held sequence does not start with a lead byte")
	`UCC_IMPLY(a_three_held_four_long, held_cnt_q == 2'd3,
		ucc_pkg::seq_len(held_q[0]) == 3'd4, "three bytes held for a short sequence")

endmodule

`default_nettype wire

FILE: rtl/ucc_queue.sv
// ---------------------------------------------------------------------------
// Decoder queue
// Small register FIFO of decoded entries between front and back end.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ucc_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ucc_pkg::entry_t wr_entry,
	input  logic            pop,
	output ucc_pkg::entry_t head,
	output logic            empty,
	output logic            full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ucc_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == CNT_W'(0));
	assign full  = (count_q == CNT_W'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	`UCC_IMPLY(a_no_push_full, push, !full, "push into full queue")
	`UCC_IMPLY(a_no_pop_empty, pop, !empty, "pop from empty queue")
	`UCC_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1,
		"queue count did not advance")

endmodule

`default_nettype wire

FILE: rtl/ucc_back.sv
// ---------------------------------------------------------------------------
// Case mapping back end
// Walks each queued entry one codepoint a step, resolves sigma and title
// words, maps and encodes to bytes and shifts one out per cycle while ready.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ucc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      case_mode,
	input  ucc_pkg::entry_t head,
	input  logic            empty,
	output logic            pop,
	ucc_out_if.source       mapped
);

	logic [2:0]  idx_q;
	logic        sigma_q;
	logic        word_q;
	logic [63:0] buf_q;
	logic [3:0]  rem_q;
	logic        last_q;
	logic        eos_q;

	logic [2:0]  nsteps;
	logic        step_last;
	logic        step_has;
	logic [20:0] step_cp;
	logic        buf_free;
	logic        step_go;
	logic        out_take;
	logic [63:0] lst;
	logic [3:0]  n;
	logic        sw;
	logic        ws;
	logic [31:0] m_bytes;
	logic [2:0]  m_n;
	ucc_pkg::enc_t enc_r;
	ucc_pkg::enc_t enc_m;
	ucc_pkg::enc_t enc_f;

	// Select the current step of the head entry
	always_comb begin
		nsteps = head.fcnt + {2'd0, head.has_cp};
		if (nsteps == 3'd0) nsteps = 3'd1;
		step_last = (idx_q == nsteps - 3'd1);
		step_has  = (idx_q < head.fcnt) || head.has_cp;
		step_cp   = (idx_q < head.fcnt) ? {13'd0, head.flush[idx_q[1:0]]} : head.cp;
	end

	// Build the byte list of this step
	always_comb begin
		lst     = '0;
		n       = 4'd0;
		sw      = sigma_q;
		ws      = word_q;
		m_bytes = '0;
		m_n     = 3'd0;
		enc_r   = ucc_pkg::encode(ucc_pkg::is_word(step_cp) ? ucc_pkg::CP_SMALL_SIGMA
			: ucc_pkg::CP_FINAL_SIGMA);
		enc_m   = ucc_pkg::encode(step_cp);
		enc_f   = ucc_pkg::encode(ucc_pkg::CP_FINAL_SIGMA);
		if (step_has) begin
			// Resolve a waiting sigma
			if (sw) begin
				lst[15:0] = enc_r.bytes[15:0];
				n  = 4'd2;
				sw = 1'b0;
			end
			case (case_mode)
				ucc_pkg::MODE_UPPER: begin
					if (step_cp == ucc_pkg::CP_SHARP_S) begin
						m_bytes = {16'd0, ucc_pkg::BYTES_SS};
						m_n     = 3'd2;
					end else begin
						enc_m = ucc_pkg::encode(ucc_pkg::map_upper(step_cp));
					end
				end
				ucc_pkg::MODE_LOWER: begin
					if (step_cp == ucc_pkg::CP_CAP_SIGMA) begin
						sw = 1'b1;
					end else begin
						enc_m = ucc_pkg::encode(ucc_pkg::map_lower(step_cp));
					end
				end
				default: begin
					if (ucc_pkg::is_word(step_cp)) begin
						enc_m = ucc_pkg::encode(word_q ? ucc_pkg::map_upper(step_cp)
							: ucc_pkg::map_lower(step_cp));
						ws = 1'b0;
					end else begin
						ws = 1'b1;
					end
				end
			endcase
			if (!(case_mode == ucc_pkg::MODE_UPPER && step_cp == ucc_pkg::CP_SHARP_S) &&
				!(case_mode == ucc_pkg::MODE_LOWER && step_cp == ucc_pkg::CP_CAP_SIGMA)) begin
				m_bytes = enc_m.bytes;
				m_n     = enc_m.n;
			end
			lst = lst | ({32'd0, m_bytes} << {n, 3'b000});
			n   = n + {1'b0, m_n};
		end
		// Close the string
		if (step_last && head.eos) begin
			if (sw) begin
				lst = lst | ({48'd0, enc_f.bytes[15:0]} << {n, 3'b000});
				n   = n + 4'd2;
				sw  = 1'b0;
			end
			ws = 1'b1;
		end
	end

	assign out_take = mapped.valid && mapped.ready;
	assign buf_free = (rem_q == 4'd0) || (out_take && rem_q == 4'd1);
	assign step_go  = !empty && buf_free;
	assign pop      = step_go && step_last;

	assign mapped.valid       = (rem_q != 4'd0);
	assign mapped.out_byte    = buf_q[7:0];
	assign mapped.run_last    = last_q && (rem_q == 4'd1);
	assign mapped.string_done = eos_q && (rem_q == 4'd1);

	// Advance steps, case state and output count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 3'd0;
			sigma_q <= 1'b0;
			word_q  <= 1'b1;
			rem_q   <= 4'd0;
			last_q  <= 1'b0;
			eos_q   <= 1'b0;
		end else if (step_go) begin
			idx_q   <= step_last ? 3'd0 : idx_q + 3'd1;
			sigma_q <= sw;
			word_q  <= ws;
			rem_q   <= n;
			last_q  <= step_last;
			eos_q   <= step_last && head.eos;
		end else if (out_take) begin
			rem_q <= rem_q - 4'd1;
		end
	end

	// Load or shift the output bytes
	always_ff @(posedge clk) begin
		if (step_go) begin
			buf_q <= lst;
		end else if (out_take) begin
			buf_q <= {8'd0, buf_q[63:8]};
		end
	end

	`UCC_CHECK(a_rem_range, rem_q <= 4'd8, "output count out of range")
	`UCC_IMPLY(a_sigma_lower, $rose(sigma_q), $past(case_mode) == ucc_pkg::MODE_LOWER,
		"sigma wait outside lower mode")
	`UCC_IMPLY(a_mid_entry, idx_q != 3'd0, !empty, "step index set with queue empty")

endmodule

`default_nettype wire

FILE: rtl/utf8_case_converter.sv
// ---------------------------------------------------------------------------
// UTF-8 case converter
// Streaming UTF-8 decoder, case mapper and re-encoder with an APB mode reg.
// ---------------------------------------------------------------------------
// The raw channel takes one byte per cycle whenever the decode queue
// (QUEUE_DEPTH entries) has room. The back end walks an entry in codepoint
// steps (one per flushed held byte plus one for the decoded codepoint) and
// shifts one output byte per cycle while the output is ready, loading the
// next step as the last byte of the previous one leaves, so plain text runs
// at one byte in and one byte out per cycle. A byte that grows to N output
// bytes holds the back end until all N have left; the input stalls once the
// queue fills. The case mode register (0 lower, 1 upper, 2 or 3 title) sits
// at address 0 and is meant to be written only while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8_case_converter #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ucc_in_if.sink      raw,
	ucc_out_if.source   mapped
);

	localparam logic [1:0] ADDR_CASE_MODE = 2'd0;

	logic [1:0]      case_mode_q;
	logic            q_push;
	logic            q_pop;
	logic            q_empty;
	logic            q_full;
	ucc_pkg::entry_t q_wr;
	ucc_pkg::entry_t q_head;

	// Register port
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_CASE_MODE) ? {30'd0, case_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_mode_q <= ucc_pkg::MODE_LOWER;
		end else if (psel && penable && pwrite && paddr == ADDR_CASE_MODE) begin
			case_mode_q <= pwdata[1:0];
		end
	end

	ucc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_wr)
	);

	ucc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	ucc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.case_mode (case_mode_q),
		.head      (q_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.mapped    (mapped)
	);

endmodule

`default_nettype wire
